/* src/gelu_activation_unit_defines.svh */
// Assertion helpers for the GELU unit. Simulation gets real checks;
// synthesis sees empty bodies.
`ifndef GELU_ACTIVATION_UNIT_DEFINES_SVH
`define GELU_ACTIVATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GELU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define GELU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GELU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define GELU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* src/gelu_pkg.sv */
package gelu_pkg;

   // Q30 fixed point
   localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
   localparam logic [63:0] Q30_MASK     = Q30_ONE - 64'd1;
   localparam logic [63:0] K_TWO_SQRTPI = 64'd1211587905;

   // Datapath constants
   localparam logic [19:0] K_CUBE   = 20'd750193;      // 0.044715 in Q24
   localparam logic [29:0] K_TANH   = 30'd856721980;   // 0.79788452 in Q30
   localparam logic [29:0] K_ERF    = 30'd759250125;   // 0.70710678 in Q30
   localparam int          AC_W     = 16;
   localparam logic [15:0] AC_LIMIT = 16'h8000;        // 8.0 in Q12
   localparam int          ROM_W    = 31;              // knot values up to 1.0 in Q30
   localparam logic [31:0] F_ONE    = 32'h4000_0000;
   localparam logic [31:0] F_TWO    = 32'h8000_0000;

   // Shift-subtract division, used only while building the knot tables.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      int          b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah, al, bh, bl;
      ah = a >> 30;
      al = a & Q30_MASK;
      bh = b >> 30;
      bl = b & Q30_MASK;
      return (ah * b) + (al * bh) + ((al * bl) >> 30);
   endfunction

   // exp(-f) for f in [0, 1], Q30
   function automatic logic [63:0] exp_frac(input logic [63:0] f);
      logic signed [63:0] sum;
      logic        [63:0] term;
      int                 k;
      sum  = $signed(Q30_ONE);
      term = Q30_ONE;
      for (k = 1; k <= 20; k++) begin
         term = udiv64((term * f) >> 30, 64'(k));
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      return (sum < 0) ? 64'd0 : $unsigned(sum);
   endfunction

   function automatic logic [63:0] scale_exp_neg(input logic [63:0] v, input logic [63:0] t);
      logic [63:0] e1, n, i, acc;
      e1  = exp_frac(Q30_ONE);
      n   = t >> 30;
      acc = mul_q30(v, exp_frac(t & Q30_MASK));
      for (i = 0; i < n; i++) begin
         acc = mul_q30(acc, e1);
      end
      return acc;
   endfunction

   function automatic logic [63:0] tanh_point(input logic [63:0] t);
      logic [63:0] e;
      e = scale_exp_neg(Q30_ONE, t << 1);
      if (e > Q30_ONE) begin
         e = Q30_ONE;
      end
      return udiv64((Q30_ONE - e) << 30, Q30_ONE + e);
   endfunction

   function automatic logic [63:0] erfc_point(input logic [63:0] z);
      logic [63:0] z2, term, sum, erf, n;
      logic        done;
      z2   = mul_q30(z, z);
      term = z;
      sum  = z;
      n    = 64'd1;
      done = 1'b0;
      while (n < 64'd200 && !done) begin
         term = udiv64(mul_q30(term, z2 << 1), (n << 1) + 64'd1);
         if (term == 64'd0) begin
            done = 1'b1;
         end else begin
            sum = sum + term;
         end
         n = n + 64'd1;
      end
      sum = scale_exp_neg(sum, z2);
      erf = mul_q30(sum, K_TWO_SQRTPI);
      if (erf > Q30_ONE) begin
         erf = Q30_ONE;
      end
      return Q30_ONE - erf;
   endfunction

   // Knot k sits at argument floor(k * 4.0 / segs), Q30
   function automatic logic [ROM_W-1:0] tanh_knot(input logic [63:0] k, input logic [63:0] segs);
      logic [63:0] v;
      v = tanh_point(udiv64(k << 32, segs));
      return v[ROM_W-1:0];
   endfunction

   function automatic logic [ROM_W-1:0] erfc_knot(input logic [63:0] k, input logic [63:0] segs);
      logic [63:0] v;
      v = erfc_point(udiv64(k << 32, segs));
      return v[ROM_W-1:0];
   endfunction

endpackage

/* src/gelu_activation_unit.sv */
// GELU activation, one Q3.12 sample per clock. A request is taken on every
// clock edge where start is high and busy is low; busy is high only while
// reset is held, so a new request may follow in every cycle. Each result
// appears on rsp_sample_out for exactly one cycle with rsp_valid high, in
// request order; the receiver cannot hold it off. The datapath has 12
// stages: cube and tanh-argument multiplies, the segment-index multiply, a
// registered two-port table read, the interpolation multiply and the final
// x*F multiply each own a stage.
// csr_fast_mode picks the tanh form (1) or the erfc form (0); write it only
// when no request is in flight. The knot tables are built at elaboration,
// so there is no fill or clearing pass after reset.
`include "gelu_activation_unit_defines.svh"

module gelu_activation_unit #(
   parameter int DATA_WIDTH = 16,
   parameter int SEGMENTS   = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_sample_in,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_sample_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_fast_mode
);

   localparam int LATENCY = 12;
   localparam int IDX_W   = $clog2(SEGMENTS + 1);
   localparam int MAG_W   = DATA_WIDTH + 1;
   localparam int CMP_W   = (DATA_WIDTH > gelu_pkg::AC_W) ? DATA_WIDTH : gelu_pkg::AC_W;
   localparam int PROD_W  = DATA_WIDTH + 32;
   localparam int ROM_W   = gelu_pkg::ROM_W;
   localparam int POS_W   = 32 + IDX_W;
   localparam int STEP_W  = ROM_W + 32;

   localparam logic [IDX_W-1:0]  SEG_K    = IDX_W'(SEGMENTS);
   localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << 30;
   localparam logic [MAG_W-1:0]  SAT_NEG  = MAG_W'(1) << (DATA_WIDTH - 1);
   localparam logic [MAG_W-1:0]  SAT_POS  = SAT_NEG - MAG_W'(1);

   // Control that rides with every sample through the pipe
   typedef struct packed {
      logic                  vld;
      logic                  neg;
      logic                  mode;
      logic [DATA_WIDTH-1:0] a;
   } ctl_type;

   // ------------------------------------------------------------------
   // Handshakes and mode register
   // ------------------------------------------------------------------
   logic req_accept;
   logic fast_mode_ff;

   assign busy       = reset;
   assign csr_ready  = !reset;
   assign req_accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         fast_mode_ff <= csr_fast_mode;
      end
   end

   // ------------------------------------------------------------------
   // Knot tables, filled by constant evaluation
   // ------------------------------------------------------------------
   logic [ROM_W-1:0] tanh_rom [SEGMENTS+1];
   logic [ROM_W-1:0] erfc_rom [SEGMENTS+1];

   for (genvar k = 0; k <= SEGMENTS; k++) begin : g_knot
      localparam logic [ROM_W-1:0] TANH_V = gelu_pkg::tanh_knot(64'(k), 64'(SEGMENTS));
      localparam logic [ROM_W-1:0] ERFC_V = gelu_pkg::erfc_knot(64'(k), 64'(SEGMENTS));
      assign tanh_rom[k] = TANH_V;
      assign erfc_rom[k] = ERFC_V;
   end

   // ------------------------------------------------------------------
   // Control shift line: ctl_ff[s] describes the sample in stage s
   // ------------------------------------------------------------------
   ctl_type               ctl_in;
   ctl_type               ctl_ff [1:LATENCY-1];
   logic [DATA_WIDTH-1:0] raw_in;

   assign raw_in      = req_sample_in;
   assign ctl_in.vld  = req_accept;
   assign ctl_in.neg  = raw_in[DATA_WIDTH-1];
   assign ctl_in.mode = fast_mode_ff;
   // Magnitude; the most negative code maps to 2^(DATA_WIDTH-1), still exact unsigned
   assign ctl_in.a    = ctl_in.neg ? (~raw_in + DATA_WIDTH'(1)) : raw_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s < LATENCY; s++) begin
            ctl_ff[s].vld <= 1'b0;
         end
      end else begin
         ctl_ff[1] <= ctl_in;
         for (int s = 2; s < LATENCY; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: clamp the table argument input to 8.0
   // ------------------------------------------------------------------
   logic [CMP_W-1:0]          a_ext;
   logic [gelu_pkg::AC_W-1:0] s1_ac_in, s1_ac_ff;

   assign a_ext    = CMP_W'(ctl_in.a);
   assign s1_ac_in = (a_ext > CMP_W'(gelu_pkg::AC_LIMIT)) ? gelu_pkg::AC_LIMIT
                                                           : a_ext[gelu_pkg::AC_W-1:0];

   // ------------------------------------------------------------------
   // Stage 2: square for the cubic term; erfc argument z = a/sqrt(2)
   // ------------------------------------------------------------------
   logic [31:0] sq_full;
   logic [45:0] z_full;
   logic [30:0] s2_sq_in, s2_sq_ff;
   logic [33:0] s2_z_in, s2_z_ff;
   logic [15:0] s2_ac_ff;

   assign sq_full  = 32'(s1_ac_ff) * 32'(s1_ac_ff);
   assign z_full   = 46'(s1_ac_ff) * 46'(gelu_pkg::K_ERF);
   assign s2_sq_in = sq_full[30:0];
   assign s2_z_in  = z_full[45:12];

   // ------------------------------------------------------------------
   // Stage 3: cube
   // ------------------------------------------------------------------
   logic [46:0] cube_full;
   logic [34:0] s3_cube_in, s3_cube_ff;
   logic [15:0] s3_ac_ff;
   logic [33:0] s3_z_ff;

   assign cube_full  = 47'(s2_sq_ff) * 47'(s2_ac_ff);
   assign s3_cube_in = cube_full[46:12];

   // ------------------------------------------------------------------
   // Stage 4: u = a + 0.044715 a^3
   // ------------------------------------------------------------------
   logic [54:0] cterm_full;
   logic [31:0] s4_u_in, s4_u_ff;
   logic [33:0] s4_z_ff;

   assign cterm_full = 55'(s3_cube_ff) * 55'(gelu_pkg::K_CUBE);
   assign s4_u_in    = {4'b0, s3_ac_ff, 12'b0} + {1'b0, cterm_full[54:24]};

   // ------------------------------------------------------------------
   // Stage 5: tanh argument; pick the form and flag saturation at 4.0
   // ------------------------------------------------------------------
   logic [61:0] t_full;
   logic [37:0] arg_sel;
   logic [31:0] s5_arg_in, s5_arg_ff;
   logic        s5_sat_in, s5_sat_ff;

   assign t_full    = 62'(s4_u_ff) * 62'(gelu_pkg::K_TANH);
   assign arg_sel   = ctl_ff[4].mode ? t_full[61:24] : {4'b0, s4_z_ff};
   assign s5_sat_in = |arg_sel[37:32];
   assign s5_arg_in = arg_sel[31:0];

   // ------------------------------------------------------------------
   // Stage 6: segment index and Q32 fraction
   // ------------------------------------------------------------------
   logic [POS_W-1:0] pos_full;
   logic [IDX_W-1:0] s6_idx_in, s6_idx_ff;
   logic [31:0]      s6_fr_in, s6_fr_ff;
   logic             s6_sat_ff;

   assign pos_full  = POS_W'(s5_arg_ff) * POS_W'(SEG_K);
   assign s6_idx_in = pos_full[32 +: IDX_W];
   assign s6_fr_in  = pos_full[31:0];

   // ------------------------------------------------------------------
   // Stage 7: registered read of both knots bounding the segment
   // ------------------------------------------------------------------
   logic [IDX_W-1:0] idx_hi;
   logic [ROM_W-1:0] s7_lo_ff, s7_hi_ff;
   logic [31:0]      s7_fr_ff;
   logic             s7_sat_ff;

   assign idx_hi = s6_idx_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      s7_lo_ff <= ctl_ff[6].mode ? tanh_rom[s6_idx_ff] : erfc_rom[s6_idx_ff];
      s7_hi_ff <= ctl_ff[6].mode ? tanh_rom[idx_hi] : erfc_rom[idx_hi];
   end

   // ------------------------------------------------------------------
   // Stage 8: slope direction and magnitude
   // ------------------------------------------------------------------
   logic             s8_up_in, s8_up_ff;
   logic [ROM_W-1:0] s8_diff_in, s8_diff_ff, s8_lo_ff;
   logic [31:0]      s8_fr_ff;
   logic             s8_sat_ff;

   assign s8_up_in   = s7_hi_ff >= s7_lo_ff;
   assign s8_diff_in = s8_up_in ? (s7_hi_ff - s7_lo_ff) : (s7_lo_ff - s7_hi_ff);

   // ------------------------------------------------------------------
   // Stage 9: interpolation step
   // ------------------------------------------------------------------
   logic [STEP_W-1:0] step_full;
   logic [ROM_W-1:0]  s9_step_in, s9_step_ff, s9_lo_ff;
   logic              s9_up_ff, s9_sat_ff;

   assign step_full  = STEP_W'(s8_diff_ff) * STEP_W'(s8_fr_ff);
   assign s9_step_in = step_full[STEP_W-1:32];

   // ------------------------------------------------------------------
   // Stage 10: table value, then F in [0, 2] by odd/even symmetry
   // ------------------------------------------------------------------
   logic [ROM_W-1:0] interp;
   logic [31:0]      fval;
   logic [31:0]      s10_f_in, s10_f_ff;

   assign interp = s9_up_ff ? (s9_lo_ff + s9_step_ff) : (s9_lo_ff - s9_step_ff);

   // Past 4.0: tanh saturates at 1, erfc of a positive argument at 0
   assign fval = s9_sat_ff ? (ctl_ff[9].mode ? gelu_pkg::F_ONE : 32'd0) : {1'b0, interp};

   always_comb begin
      if (ctl_ff[9].mode) begin
         s10_f_in = ctl_ff[9].neg ? (gelu_pkg::F_ONE - fval) : (gelu_pkg::F_ONE + fval);
      end else begin
         s10_f_in = ctl_ff[9].neg ? fval : (gelu_pkg::F_TWO - fval);
      end
   end

   // ------------------------------------------------------------------
   // Stage 11: |x| * F / 2, round half away from zero
   // ------------------------------------------------------------------
   logic [PROD_W-1:0] af_full, af_rnd;
   logic [MAG_W-1:0]  s11_mag_in, s11_mag_ff;

   assign af_full    = PROD_W'(ctl_ff[10].a) * PROD_W'(s10_f_ff);
   assign af_rnd     = af_full + RND_HALF;
   assign s11_mag_in = af_rnd[PROD_W-1:31];

   // ------------------------------------------------------------------
   // Stage 12: saturate, restore sign, drive the result strobe
   // ------------------------------------------------------------------
   logic [MAG_W-1:0]      mag_neg, mag_pos, mag_twos;
   logic [DATA_WIDTH-1:0] rsp_sample_out_in, rsp_sample_out_ff;
   logic                  rsp_valid_ff;

   assign mag_neg  = (s11_mag_ff > SAT_NEG) ? SAT_NEG : s11_mag_ff;
   assign mag_pos  = (s11_mag_ff > SAT_POS) ? SAT_POS : s11_mag_ff;
   assign mag_twos = ~mag_neg + MAG_W'(1);
   assign rsp_sample_out_in = ctl_ff[11].neg ? mag_twos[DATA_WIDTH-1:0]
                                             : mag_pos[DATA_WIDTH-1:0];

   // Payload registers: no reset, validity lives in ctl_ff
   always_ff @(posedge clock) begin
      s1_ac_ff          <= s1_ac_in;
      s2_sq_ff          <= s2_sq_in;
      s2_z_ff           <= s2_z_in;
      s2_ac_ff          <= s1_ac_ff;
      s3_cube_ff        <= s3_cube_in;
      s3_ac_ff          <= s2_ac_ff;
      s3_z_ff           <= s2_z_ff;
      s4_u_ff           <= s4_u_in;
      s4_z_ff           <= s3_z_ff;
      s5_arg_ff         <= s5_arg_in;
      s5_sat_ff         <= s5_sat_in;
      s6_idx_ff         <= s6_idx_in;
      s6_fr_ff          <= s6_fr_in;
      s6_sat_ff         <= s5_sat_ff;
      s7_fr_ff          <= s6_fr_ff;
      s7_sat_ff         <= s6_sat_ff;
      s8_up_ff          <= s8_up_in;
      s8_diff_ff        <= s8_diff_in;
      s8_lo_ff          <= s7_lo_ff;
      s8_fr_ff          <= s7_fr_ff;
      s8_sat_ff         <= s7_sat_ff;
      s9_step_ff        <= s9_step_in;
      s9_lo_ff          <= s8_lo_ff;
      s9_up_ff          <= s8_up_ff;
      s9_sat_ff         <= s8_sat_ff;
      s10_f_ff          <= s10_f_in;
      s11_mag_ff        <= s11_mag_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_ff[LATENCY-1].vld;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // Every strobe traces back to an accepted request
   `GELU_ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_valid_ff, $past(req_accept, LATENCY), "result strobe without matching request")
   // A non-negative sample never yields a negative result
   `GELU_ASSERT_NEXT(a_pos_nonneg, clock, reset, ctl_ff[11].vld && !ctl_ff[11].neg, !rsp_sample_out_ff[DATA_WIDTH-1], "positive sample gave negative result")
   // For negative samples F <= 1, so the magnitude cannot grow
   `GELU_ASSERT_IMPL(a_neg_bound, clock, reset, ctl_ff[11].vld && ctl_ff[11].neg, s11_mag_ff <= MAG_W'(ctl_ff[11].a), "negative sample magnitude grew")
   // F stays within [0, 2]
   `GELU_ASSERT_NEXT(a_f_range, clock, reset, ctl_ff[9].vld, s10_f_ff <= gelu_pkg::F_TWO, "GELU factor out of range")

endmodule

/* tb/tb_gelu_activation_unit.sv */
module tb_gelu_activation_unit;

   // Request rate: one sample per clock. Results come back in request order
   // and cannot be held off by the receiver.
   localparam int LATENCY     = 12;
   localparam int LUT_SEGS    = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 175;
   localparam int ROW_COUNT   = 25;

   // Fixed-point constants of the GELU datapath (Q30 magnitudes unless noted)
   localparam bit [63:0] ONE_Q30        = 64'd1 << 30;
   localparam bit [63:0] FRAC_MASK      = ONE_Q30 - 64'd1;
   localparam bit [63:0] ARG_SAT        = 64'd4 << 30;      // table covers |arg| < 4.0
   localparam bit [63:0] X_CLAMP        = 64'd8 << 12;      // 8.0 in Q12
   localparam bit [63:0] CUBE_Q24       = 64'd750193;       // 0.044715 in Q24
   localparam bit [63:0] TANH_GAIN      = 64'd856721980;    // sqrt(2/pi)
   localparam bit [63:0] ERF_GAIN       = 64'd759250125;    // 1/sqrt(2)
   localparam bit [63:0] TWO_OVER_SQRTPI = 64'd1211587905;

   typedef enum bit {
      MODE_ERFC = 1'b0,
      MODE_TANH = 1'b1
   } gelu_mode_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] gelu;
   } gelu_pair_type;

   typedef struct packed {
      gelu_mode_type      mode;
      logic signed [15:0] sample;
      bit                 known;
      logic signed [15:0] gelu;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_sample_in;
   logic               rsp_valid;
   logic signed [15:0] rsp_sample_out;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_fast_mode;

   // Side channel that travels with each request: a hand-typed expectation
   logic               req_known;
   logic signed [15:0] req_known_gelu;

   bit [31:0]     tanh_knots [0:LUT_SEGS];
   bit [31:0]     erfc_knots [0:LUT_SEGS];
   gelu_pair_type gelu_expected [$];
   gelu_mode_type fast_mode_q = MODE_ERFC;
   int            error_count = 0;
   int            stall_count = 0;

   // Directed requests. The expected result is typed in where it is obvious:
   // zero input, and inputs so large that the table saturates and GELU(x) is
   // either x itself or zero. Everything else goes to the predictor.
   stim_row_type directed_rows [ROW_COUNT] = '{
      // erfc form (reset value)
      '{MODE_ERFC,  16'sd0,     1'b1, 16'sd0},
      '{MODE_ERFC,  16'sd32767, 1'b1, 16'sd32767},   // positive extreme, saturated erfc
      '{MODE_ERFC, -16'sd32768, 1'b1, 16'sd0},       // negative extreme, |x| clamps to 8.0
      '{MODE_ERFC, -16'sd32767, 1'b1, 16'sd0},
      '{MODE_ERFC,  16'sd1,     1'b0, 16'sd0},       // one LSB: rounding of tiny products
      '{MODE_ERFC, -16'sd1,     1'b0, 16'sd0},
      '{MODE_ERFC,  16'sd4096,  1'b0, 16'sd0},       // +/-1.0 falls between two knots
      '{MODE_ERFC, -16'sd4096,  1'b0, 16'sd0},
      '{MODE_ERFC,  16'sd23170, 1'b0, 16'sd0},       // erfc argument just under 4.0
      '{MODE_ERFC,  16'sd23171, 1'b0, 16'sd0},       // and just over it
      '{MODE_ERFC, -16'sd23170, 1'b0, 16'sd0},
      '{MODE_ERFC, -16'sd23171, 1'b0, 16'sd0},
      // tanh form
      '{MODE_TANH,  16'sd0,     1'b1, 16'sd0},
      '{MODE_TANH,  16'sd32767, 1'b1, 16'sd32767},
      '{MODE_TANH, -16'sd32768, 1'b1, 16'sd0},
      '{MODE_TANH, -16'sd32767, 1'b1, 16'sd0},
      '{MODE_TANH,  16'sd16384, 1'b1, 16'sd16384},   // 4.0: tanh argument well past 4.0
      '{MODE_TANH,  16'sd1,     1'b0, 16'sd0},
      '{MODE_TANH, -16'sd1,     1'b0, 16'sd0},
      '{MODE_TANH,  16'sd13700, 1'b0, 16'sd0},       // tanh argument just over 4.0
      '{MODE_TANH,  16'sd13702, 1'b0, 16'sd0},
      '{MODE_TANH, -16'sd13700, 1'b0, 16'sd0},
      '{MODE_TANH, -16'sd13702, 1'b0, 16'sd0},
      '{MODE_TANH,  16'sd4096,  1'b0, 16'sd0},
      '{MODE_TANH, -16'sd4096,  1'b0, 16'sd0}
   };

   gelu_activation_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_fast_mode  (csr_fast_mode)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // GELU predictor: knot tables built here, then linear interpolation
   // ---------------------------------------------------------------------

   // (a*b)>>30 split so the partial products stay inside 64 bits
   function automatic bit [63:0] q30_mul(input bit [63:0] a, input bit [63:0] b);
      bit [63:0] ah, al, bh, bl;
      ah = a >> 30;
      al = a & FRAC_MASK;
      bh = b >> 30;
      bl = b & FRAC_MASK;
      return ah * b + al * bh + ((al * bl) >> 30);
   endfunction

   // exp(-f) for f in [0, 1], 20 Taylor terms, truncating at each step
   function automatic bit [63:0] exp_neg_frac(input bit [63:0] f);
      longint    acc;
      bit [63:0] term;
      int        k;
      acc  = longint'(ONE_Q30);
      term = ONE_Q30;
      for (k = 1; k <= 20; k++) begin
         term = ((term * f) >> 30) / 64'(k);
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      return (acc < 0) ? 64'd0 : 64'(acc);
   endfunction

   // v * exp(-t): fractional part by series, whole part by repeated exp(-1)
   function automatic bit [63:0] exp_scale(input bit [63:0] v, input bit [63:0] t);
      bit [63:0] e1, acc, whole, i;
      e1    = exp_neg_frac(ONE_Q30);
      whole = t >> 30;
      acc   = q30_mul(v, exp_neg_frac(t & FRAC_MASK));
      for (i = 0; i < whole; i++) begin
         acc = q30_mul(acc, e1);
      end
      return acc;
   endfunction

   function automatic bit [63:0] tanh_knot_value(input bit [63:0] t);
      bit [63:0] e;
      e = exp_scale(ONE_Q30, 2 * t);
      if (e > ONE_Q30) begin
         e = ONE_Q30;
      end
      return ((ONE_Q30 - e) << 30) / (ONE_Q30 + e);
   endfunction

   // erfc = 1 - erf, erf from the all-positive series times exp(-z^2)
   function automatic bit [63:0] erfc_knot_value(input bit [63:0] z);
      bit [63:0] z2, term, sum, erf, n;
      z2   = q30_mul(z, z);
      term = z;
      sum  = z;
      for (n = 1; n < 200; n++) begin
         term = q30_mul(term, 2 * z2) / (2 * n + 1);
         if (term == 64'd0) begin
            break;
         end
         sum = sum + term;
      end
      sum = exp_scale(sum, z2);
      erf = q30_mul(sum, TWO_OVER_SQRTPI);
      if (erf > ONE_Q30) begin
         erf = ONE_Q30;
      end
      return ONE_Q30 - erf;
   endfunction

   // Interpolate between knots; segment fraction carried in Q32
   function automatic bit [63:0] knot_interp(input bit pick_tanh, input bit [63:0] t);
      bit [63:0] pos, seg, fr, lo, hi;
      bit [6:0]  seg_lo, seg_hi;
      pos = t * 64'(LUT_SEGS);
      seg = pos >> 32;
      fr  = pos & 64'hFFFF_FFFF;
      if (seg >= 64'(LUT_SEGS)) begin
         seg = 64'(LUT_SEGS - 1);
      end
      seg_lo = seg[6:0];
      seg_hi = seg_lo + 7'd1;
      lo = 64'(pick_tanh ? tanh_knots[seg_lo] : erfc_knots[seg_lo]);
      hi = 64'(pick_tanh ? tanh_knots[seg_hi] : erfc_knots[seg_hi]);
      if (hi >= lo) begin
         return lo + (((hi - lo) * fr) >> 32);
      end
      return lo - (((lo - hi) * fr) >> 32);
   endfunction

   function automatic logic signed [15:0] gelu_predict(input bit [15:0] raw,
                                                       input gelu_mode_type mode);
      bit        neg;
      bit [63:0] a, ac, a3, u, arg, lut, f, mag;
      neg = raw[15];
      a   = neg ? 64'h1_0000 - 64'(raw) : 64'(raw);
      ac  = (a > X_CLAMP) ? X_CLAMP : a;
      if (mode == MODE_TANH) begin
         a3  = (ac * ac * ac) >> 12;
         u   = (ac << 12) + ((a3 * CUBE_Q24) >> 24);
         arg = (u * TANH_GAIN) >> 24;
         lut = (arg >= ARG_SAT) ? ONE_Q30 : knot_interp(1'b1, arg);
         f   = neg ? ONE_Q30 - lut : ONE_Q30 + lut;
      end else begin
         // erfc(-z) = 2 - erfc(z) covers positive x
         arg = (ac * ERF_GAIN) >> 12;
         lut = (arg >= ARG_SAT) ? 64'd0 : knot_interp(1'b0, arg);
         f   = neg ? lut : 2 * ONE_Q30 - lut;
      end
      // round half away from zero on the magnitude, then clamp per sign
      mag = (a * f + ONE_Q30) >> 31;
      if (neg) begin
         if (mag > 64'h8000) begin
            mag = 64'h8000;
         end
         return 16'(64'h1_0000 - mag);
      end
      if (mag > 64'h7FFF) begin
         mag = 64'h7FFF;
      end
      return 16'(mag);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: predict every accepted request, check every result strobe
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         fast_mode_q = MODE_ERFC;
      end else begin
         // check first: a result can never belong to a request taken this edge
         if (rsp_valid) begin
            if (gelu_expected.size() == 0) begin
               report_mismatch($sformatf("result %0d with no request outstanding",
                                         rsp_sample_out));
            end else if (rsp_sample_out !== gelu_expected[0].gelu) begin
               report_mismatch($sformatf("sample %0d: got %0d, want %0d",
                                         gelu_expected[0].sample, rsp_sample_out,
                                         gelu_expected[0].gelu));
               void'(gelu_expected.pop_front());
            end else begin
               void'(gelu_expected.pop_front());
            end
         end
         if (start && !busy) begin
            gelu_expected.push_back('{sample: req_sample_in,
                                      gelu: req_known ? req_known_gelu
                                                      : gelu_predict(req_sample_in,
                                                                     fast_mode_q)});
         end
         if (csr_valid && csr_ready) begin
            fast_mode_q = gelu_mode_type'(csr_fast_mode);
         end
         // any handshake or strobe counts as progress for the watchdog
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_count = 0;
         end else begin
            stall_count++;
         end
      end
   end

   // Watchdog: end the run when nothing has moved for too long
   initial begin
      wait (stall_count >= STALL_LIMIT);
      $display("tb_gelu_activation_unit: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Hold start low for a random number of cycles, then present the request
   // and hold it until busy is low at a rising edge.
   task automatic send_request(input logic signed [15:0] x, input bit known,
                               input logic signed [15:0] known_gelu, input int idle_pct);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start         <= 1'b0;
         req_sample_in <= 16'($urandom);   // scramble: must be ignored while idle
         @(posedge clock);
      end
      start          <= 1'b1;
      req_sample_in  <= x;
      req_known      <= known;
      req_known_gelu <= known_gelu;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every outstanding request has produced its result
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (gelu_expected.size() != 0);
   endtask

   task automatic write_mode(input gelu_mode_type mode);
      csr_valid     <= 1'b1;
      csr_fast_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      gelu_mode_type      cur_mode;
      logic signed [15:0] x;
      int                 k, r, p, n, idle_pct;

      for (k = 0; k <= LUT_SEGS; k++) begin
         tanh_knots[k] = 32'(tanh_knot_value((64'(k) << 32) / 64'(LUT_SEGS)));
         erfc_knots[k] = 32'(erfc_knot_value((64'(k) << 32) / 64'(LUT_SEGS)));
      end

      reset          <= 1'b1;
      start          <= 1'b0;
      req_sample_in  <= '0;
      req_known      <= 1'b0;
      req_known_gelu <= '0;
      csr_valid      <= 1'b0;
      csr_fast_mode  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed rows back to back; switch the mode only once drained
      cur_mode = MODE_ERFC;
      for (r = 0; r < ROW_COUNT; r++) begin
         if (directed_rows[r].mode != cur_mode) begin
            wait_drained();
            cur_mode = directed_rows[r].mode;
            write_mode(cur_mode);
         end
         send_request(directed_rows[r].sample, directed_rows[r].known,
                      directed_rows[r].gelu, 0);
      end

      // Random phases: walk every mode against every sender idle pattern
      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         cur_mode = gelu_mode_type'(p % 2);
         write_mode(cur_mode);
         idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 74 : 30;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // full range, then the table's working range, then values near zero
            r = $urandom_range(99);
            if (r < 50) begin
               x = 16'($urandom);
            end else if (r < 85) begin
               x = 16'(int'($urandom_range(49152)) - 24576);
            end else begin
               x = 16'(int'($urandom_range(1024)) - 512);
            end
            send_request(x, 1'b0, 16'sd0, idle_pct);
         end
      end

      wait_drained();
      // hold a little longer to catch any stray result strobe
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_gelu_activation_unit: done, clean");
      end else begin
         $display("tb_gelu_activation_unit: done, errors");
      end
      $finish;
   end

endmodule
